/* src/layer_stack_order_manager_defines.svh */
// Assertion helpers for the layer stack order manager.
`ifndef LAYER_STACK_ORDER_MANAGER_DEFINES_SVH
`define LAYER_STACK_ORDER_MANAGER_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define LSOM_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define LSOM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/lsom_pkg.sv */
`default_nettype none

package lsom_pkg;

    localparam int LAYER_COUNT = 256;
    localparam int LAYER_W     = 8;
    localparam int HEIGHT_W    = 9;
    localparam int CNT_W       = 9;

    typedef logic [LAYER_W-1:0]         t_layer;
    typedef logic signed [HEIGHT_W-1:0] t_height;
    typedef logic [1:0]                 t_opcode;

    localparam t_opcode OP_ALLOC = 2'd0;
    localparam t_opcode OP_SET   = 2'd1;
    localparam t_opcode OP_FREE  = 2'd2;

    localparam t_height HEIGHT_NONE = -9'sd1;

endpackage

`default_nettype wire

/* src/lsom_if.sv */
`default_nettype none

interface lsom_req_if;
    logic                 valid;
    logic                 ready;
    lsom_pkg::t_opcode    opcode;
    lsom_pkg::t_layer     layer;
    lsom_pkg::t_height    requested_height;

    modport source (output valid, output opcode, output layer, output requested_height,
                    input ready);
    modport sink (input valid, input opcode, input layer, input requested_height,
                  output ready);
endinterface

interface lsom_rsp_if;
    logic                 valid;
    logic                 ready;
    logic                 status;
    lsom_pkg::t_layer     allocated_layer;
    lsom_pkg::t_height    applied_height;
    lsom_pkg::t_height    visible_top;

    modport source (output valid, output status, output allocated_layer,
                    output applied_height, output visible_top, input ready);
    modport sink (input valid, input status, input allocated_layer,
                  input applied_height, input visible_top, output ready);
endinterface

`default_nettype wire

/* src/layer_stack_order_manager.sv */
// Z-order manager for a pool of display layers.
// Requests arrive on i_req (opcode, layer, requested_height) and each one gives
// exactly one response on o_rsp (status, allocated_layer, applied_height,
// visible_top). Both channels move a request at a clock edge where valid and
// ready are high.
// The block works on one request at a time and drops i_req.ready until that
// request's response has been loaded into the output register.
// An allocate scans the in-use flags one layer per cycle. A set-height or free
// reads the layer's slot and plans the move; unless the layer keeps its slot,
// it then runs the stack memory through one shift per cycle with a pipelined
// read and write port and finally writes the layer into its new slot or hides it.
// A response waits in the output register while o_rsp.ready is low; a new
// request is taken meanwhile, but its response is held until the register frees.
// Synchronous reset hides every layer, releases every layer and empties the
// stack at once; no clearing pass is needed.
`default_nettype none
`include "layer_stack_order_manager_defines.svh"

module layer_stack_order_manager (
    input  wire            i_clk,
    input  wire            i_rst_n,
    lsom_req_if.sink       i_req,
    lsom_rsp_if.source     o_rsp
);

    typedef logic signed [lsom_pkg::HEIGHT_W:0] t_wide;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RDPOS = 3'd1;
    localparam logic [2:0] S_PLAN  = 3'd2;
    localparam logic [2:0] S_SHIFT = 3'd3;
    localparam logic [2:0] S_FINAL = 3'd4;
    localparam logic [2:0] S_ALLOC = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    localparam t_wide W_NEG1 = t_wide'(-1);
    localparam t_wide W_ONE  = t_wide'(1);
    localparam t_wide W_LAST = t_wide'(lsom_pkg::LAYER_COUNT - 1);

    logic [2:0]                         r_state;
    lsom_pkg::t_opcode                  r_op;
    lsom_pkg::t_layer                   r_lay;
    lsom_pkg::t_height                  r_req;
    lsom_pkg::t_height                  r_top;
    lsom_pkg::t_height                  r_h;
    lsom_pkg::t_layer                   r_idx;
    lsom_pkg::t_layer                   r_dst;
    lsom_pkg::t_layer                   r_wr_dst;
    logic [lsom_pkg::CNT_W-1:0]         r_cnt;
    logic                               r_dir_down;
    logic                               r_wr_pend;
    logic                               r_fin_hide;
    logic                               r_top_inc;
    logic                               r_status;
    lsom_pkg::t_layer                   r_given;
    lsom_pkg::t_height                  r_applied;

    logic                               r_out_valid;
    logic                               r_out_status;
    lsom_pkg::t_layer                   r_out_given;
    lsom_pkg::t_height                  r_out_applied;
    lsom_pkg::t_height                  r_out_top;

    lsom_pkg::t_layer                   r_stack_mem [lsom_pkg::LAYER_COUNT];
    lsom_pkg::t_height                  r_pos_mem [lsom_pkg::LAYER_COUNT];
    logic [lsom_pkg::LAYER_COUNT-1:0]   r_pos_vld;
    logic [lsom_pkg::LAYER_COUNT-1:0]   r_in_use;
    lsom_pkg::t_layer                   r_so_q;
    lsom_pkg::t_height                  r_pos_q;
    logic                               r_pos_q_vld;

    logic                               in_acc;
    logic                               out_load;
    lsom_pkg::t_layer                   stk_ra;
    logic                               stk_we;
    lsom_pkg::t_layer                   stk_wa;
    lsom_pkg::t_layer                   stk_wd;
    logic                               pos_we;
    lsom_pkg::t_layer                   pos_wa;
    lsom_pkg::t_height                  pos_wd;

    logic signed [lsom_pkg::HEIGHT_W:0] w_old;
    logic signed [lsom_pkg::HEIGHT_W:0] w_top;
    logic signed [lsom_pkg::HEIGHT_W:0] w_h;
    logic signed [lsom_pkg::HEIGHT_W:0] w_cnt;
    logic signed [lsom_pkg::HEIGHT_W:0] w_dst;
    logic                               p_move;
    logic                               p_dir_down;
    logic                               p_hide;
    logic                               p_inc;

    assign in_acc      = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == S_IDLE);
    assign out_load    = (r_state == S_DONE) && (!r_out_valid || o_rsp.ready);

    assign o_rsp.valid           = r_out_valid;
    assign o_rsp.status          = r_out_status;
    assign o_rsp.allocated_layer = r_out_given;
    assign o_rsp.applied_height  = r_out_applied;
    assign o_rsp.visible_top     = r_out_top;

    // Clamp the requested height and pick the shift run for the move.
    always_comb begin
        w_old = r_pos_q_vld ? {r_pos_q[lsom_pkg::HEIGHT_W-1], r_pos_q} : W_NEG1;
        w_top = {r_top[lsom_pkg::HEIGHT_W-1], r_top};
        w_h   = {r_req[lsom_pkg::HEIGHT_W-1], r_req};
        if (w_h < W_NEG1) begin
            w_h = W_NEG1;
        end
        if (r_op == lsom_pkg::OP_FREE) begin
            w_h = W_NEG1;
        end
        if (w_old >= 0) begin
            if (w_h > w_top) begin
                w_h = w_top;
            end
        end else begin
            if (w_h > w_top + W_ONE) begin
                w_h = w_top + W_ONE;
            end
            if (w_h >= 0 && w_top >= W_LAST) begin
                w_h = w_old;
            end
        end
        p_move     = (w_h != w_old);
        p_dir_down = 1'b0;
        p_hide     = 1'b0;
        p_inc      = 1'b0;
        w_dst      = w_old;
        w_cnt      = '0;
        if (w_old > w_h) begin
            if (w_h >= 0) begin
                p_dir_down = 1'b1;
                w_cnt      = w_old - w_h;
            end else begin
                p_hide = 1'b1;
                w_cnt  = w_top - w_old;
            end
        end else if (w_old >= 0) begin
            w_cnt = w_h - w_old;
        end else begin
            p_dir_down = 1'b1;
            p_inc      = 1'b1;
            w_dst      = w_top + W_ONE;
            w_cnt      = w_top - w_h + W_ONE;
        end
    end

    always_comb begin
        stk_ra = r_dir_down ? r_dst - 1'b1 : r_dst + 1'b1;
        stk_we = 1'b0;
        stk_wa = r_wr_dst;
        stk_wd = r_so_q;
        pos_we = 1'b0;
        pos_wa = r_so_q;
        pos_wd = {1'b0, r_wr_dst};
        if (r_state == S_SHIFT && r_wr_pend) begin
            stk_we = 1'b1;
            pos_we = 1'b1;
        end else if (r_state == S_FINAL && !r_fin_hide) begin
            stk_we = 1'b1;
            stk_wa = r_h[lsom_pkg::LAYER_W-1:0];
            stk_wd = r_lay;
            pos_we = 1'b1;
            pos_wa = r_lay;
            pos_wd = r_h;
        end
    end

    always_ff @(posedge i_clk) begin
        if (stk_we) begin
            r_stack_mem[stk_wa] <= stk_wd;
        end
        r_so_q <= r_stack_mem[stk_ra];
    end

    always_ff @(posedge i_clk) begin
        if (pos_we) begin
            r_pos_mem[pos_wa] <= pos_wd;
        end
        r_pos_q <= r_pos_mem[r_lay];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_vld   <= '0;
            r_pos_q_vld <= 1'b0;
        end else begin
            r_pos_q_vld <= r_pos_vld[r_lay];
            if (pos_we) begin
                r_pos_vld[pos_wa] <= 1'b1;
            end
            if (r_state == S_FINAL && r_fin_hide) begin
                r_pos_vld[r_lay] <= 1'b0;
            end
            if (r_state == S_ALLOC && !r_in_use[r_idx]) begin
                r_pos_vld[r_idx] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_top       <= lsom_pkg::HEIGHT_NONE;
            r_in_use    <= '0;
            r_wr_pend   <= 1'b0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid   <= 1'b1;
                r_out_status  <= r_status;
                r_out_given   <= r_given;
                r_out_applied <= r_applied;
                r_out_top     <= r_top;
            end else if (r_out_valid && o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_op      <= i_req.opcode;
                        r_lay     <= i_req.layer;
                        r_req     <= i_req.requested_height;
                        r_status  <= 1'b0;
                        r_given   <= '0;
                        r_applied <= lsom_pkg::HEIGHT_NONE;
                        r_idx     <= '0;
                        r_state   <= (i_req.opcode == lsom_pkg::OP_ALLOC) ? S_ALLOC : S_RDPOS;
                    end
                end
                S_RDPOS: begin
                    r_state <= S_PLAN;
                end
                S_PLAN: begin
                    r_h        <= w_h[lsom_pkg::HEIGHT_W-1:0];
                    r_dst      <= w_dst[lsom_pkg::LAYER_W-1:0];
                    r_cnt      <= w_cnt[lsom_pkg::CNT_W-1:0];
                    r_dir_down <= p_dir_down;
                    r_fin_hide <= p_hide;
                    r_top_inc  <= p_inc;
                    r_wr_pend  <= 1'b0;
                    if (r_op == lsom_pkg::OP_SET) begin
                        r_applied <= w_h[lsom_pkg::HEIGHT_W-1:0];
                    end
                    if ((r_op == lsom_pkg::OP_SET || r_op == lsom_pkg::OP_FREE) && p_move) begin
                        r_state <= S_SHIFT;
                    end else begin
                        if (r_op == lsom_pkg::OP_FREE) begin
                            r_in_use[r_lay] <= 1'b0;
                        end
                        r_state <= S_DONE;
                    end
                end
                S_SHIFT: begin
                    if (r_cnt != '0) begin
                        r_wr_pend <= 1'b1;
                        r_wr_dst  <= r_dst;
                        r_dst     <= r_dir_down ? r_dst - 1'b1 : r_dst + 1'b1;
                        r_cnt     <= r_cnt - 1'b1;
                    end else begin
                        r_wr_pend <= 1'b0;
                        if (!r_wr_pend) begin
                            r_state <= S_FINAL;
                        end
                    end
                end
                S_FINAL: begin
                    if (r_fin_hide) begin
                        r_top <= r_top - 1'b1;
                    end else if (r_top_inc) begin
                        r_top <= r_top + 1'b1;
                    end
                    if (r_op == lsom_pkg::OP_FREE) begin
                        r_in_use[r_lay] <= 1'b0;
                    end
                    r_state <= S_DONE;
                end
                S_ALLOC: begin
                    if (!r_in_use[r_idx]) begin
                        r_in_use[r_idx] <= 1'b1;
                        r_given         <= r_idx;
                        r_state         <= S_DONE;
                    end else if (r_idx == lsom_pkg::t_layer'(lsom_pkg::LAYER_COUNT - 1)) begin
                        r_status <= 1'b1;
                        r_state  <= S_DONE;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_DONE: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `LSOM_ASSERT_NEXT(a_busy_after_req, i_clk, i_rst_n, in_acc, !i_req.ready, "ready stayed high after a request")
    `LSOM_ASSERT_SAME(a_shift_write_in_shift, i_clk, i_rst_n, r_wr_pend, r_state == S_SHIFT, "stack shift write pending outside the shift phase")
    `LSOM_ASSERT_SAME(a_no_push_when_full, i_clk, i_rst_n, r_state == S_FINAL && r_top_inc && !r_fin_hide, r_top != lsom_pkg::t_height'(lsom_pkg::LAYER_COUNT - 1), "layer inserted into a full stack")
    `LSOM_ASSERT_SAME(a_rsp_from_done, i_clk, i_rst_n, $rose(r_out_valid), $past(r_state == S_DONE), "response loaded without a finished request")

endmodule

`default_nettype wire

/* tb/layer_stack_order_manager_checker.sv */
`timescale 1ns / 1ps

module layer_stack_order_manager_checker (
    input  wire   i_clk,
    input  wire   i_rst_n,
    lsom_req_if   i_req,
    lsom_rsp_if   i_rsp,
    output int    o_fail_count,
    output int    o_pending
);

    typedef struct packed {
        logic                 status;
        lsom_pkg::t_layer     allocated_layer;
        lsom_pkg::t_height    applied_height;
        lsom_pkg::t_height    visible_top;
    } t_stack_reply;

    lsom_pkg::t_layer slot_layer [lsom_pkg::LAYER_COUNT];
    int               layer_height [lsom_pkg::LAYER_COUNT];
    bit               layer_taken [lsom_pkg::LAYER_COUNT];
    int               top_index;
    t_stack_reply     expected_replies [$];

    function automatic int read_slot(int s);
        if (s < 0 || s >= lsom_pkg::LAYER_COUNT) return 0;
        return int'(slot_layer[s]);
    endfunction

    function automatic void write_slot(int s, int lay);
        if (s < 0 || s >= lsom_pkg::LAYER_COUNT || lay < 0 || lay >= lsom_pkg::LAYER_COUNT) return;
        slot_layer[s] = lsom_pkg::t_layer'(lay);
        layer_height[lay] = s;
    endfunction

    // A visible layer can only be moved up to the current top, a hidden one may go
    // one above it unless the stack is already full.
    function automatic int restack(int lay, int height);
        int old;
        int h;
        old = layer_height[lay];
        if (height < -1) height = -1;
        if (old >= 0) begin
            if (height > top_index) height = top_index;
        end else begin
            if (height > top_index + 1) height = top_index + 1;
            if (height >= 0 && top_index >= lsom_pkg::LAYER_COUNT - 1) return old;
        end
        if (height < -1) height = -1;
        if (old > height) begin
            if (height >= 0) begin
                for (h = old; h > height; h--) write_slot(h, read_slot(h - 1));
                write_slot(height, lay);
            end else begin
                for (h = old; h < top_index; h++) write_slot(h, read_slot(h + 1));
                layer_height[lay] = -1;
                if (top_index >= 0) top_index--;
            end
        end else if (old < height) begin
            if (old >= 0) begin
                for (h = old; h < height; h++) write_slot(h, read_slot(h + 1));
                write_slot(height, lay);
            end else begin
                for (h = top_index; h >= height; h--) write_slot(h + 1, read_slot(h));
                write_slot(height, lay);
                top_index++;
            end
        end
        return layer_height[lay];
    endfunction

    function automatic t_stack_reply predict_reply(lsom_pkg::t_opcode op,
                                                   lsom_pkg::t_layer lay,
                                                   lsom_pkg::t_height req);
        t_stack_reply r;
        int           applied;
        int           i;
        r = '0;
        applied = -1;
        case (op)
            lsom_pkg::OP_ALLOC: begin
                r.status = 1'b1;
                for (i = 0; i < lsom_pkg::LAYER_COUNT; i++) begin
                    if (!layer_taken[i]) begin
                        layer_taken[i] = 1'b1;
                        layer_height[i] = -1;
                        r.status = 1'b0;
                        r.allocated_layer = lsom_pkg::t_layer'(i);
                        break;
                    end
                end
            end
            lsom_pkg::OP_SET: begin
                applied = restack(int'(lay), int'(req));
            end
            lsom_pkg::OP_FREE: begin
                if (layer_height[lay] >= 0) void'(restack(int'(lay), -1));
                layer_taken[lay] = 1'b0;
            end
            default: begin
            end
        endcase
        r.applied_height = lsom_pkg::t_height'(applied);
        r.visible_top = lsom_pkg::t_height'(top_index);
        return r;
    endfunction

    function automatic void note_failure(string what);
        o_fail_count++;
        if (o_fail_count <= 10) $display("[%0t] MISMATCH: %s", $realtime, what);
    endfunction

    always @(posedge i_clk) begin : watch
        t_stack_reply want;
        int           i;
        if (!i_rst_n) begin
            for (i = 0; i < lsom_pkg::LAYER_COUNT; i++) begin
                layer_height[i] = -1;
                layer_taken[i] = 1'b0;
            end
            top_index = -1;
            expected_replies.delete();
            o_fail_count = 0;
        end else begin
            if (i_rsp.valid && i_rsp.ready) begin
                if (expected_replies.size() == 0) begin
                    note_failure("response with no request outstanding");
                end else begin
                    want = expected_replies.pop_front();
                    if (i_rsp.status !== want.status
                            || i_rsp.allocated_layer !== want.allocated_layer
                            || i_rsp.applied_height !== want.applied_height
                            || i_rsp.visible_top !== want.visible_top) begin
                        note_failure($sformatf(
                            "expected status %0d layer %0d height %0d top %0d, got %0d %0d %0d %0d",
                            want.status, want.allocated_layer, want.applied_height,
                            want.visible_top, i_rsp.status, i_rsp.allocated_layer,
                            i_rsp.applied_height, i_rsp.visible_top));
                    end
                end
            end
            if (i_req.valid && i_req.ready) begin
                expected_replies.push_back(predict_reply(i_req.opcode, i_req.layer,
                                                         i_req.requested_height));
            end
        end
        o_pending = expected_replies.size();
    end

endmodule

/* tb/layer_stack_order_manager_test.sv */
`timescale 1ns / 1ps

module layer_stack_order_manager_test;

    localparam lsom_pkg::t_opcode OP_RESERVED    = 2'd3;
    localparam int                DRAIN_CYCLES   = 300;
    localparam int                WATCHDOG_LIMIT = 4000;
    localparam int                HOLD_CYCLES    = 400;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    bit   no_idle;
    bit   hold_off_req;
    int   layer_order [lsom_pkg::LAYER_COUNT];

    lsom_req_if req_bus ();
    lsom_rsp_if rsp_bus ();

    layer_stack_order_manager i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus)
    );

    layer_stack_order_manager_checker u_reply_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_bus),
        .i_rsp        (rsp_bus),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic int pick_gap();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 15);
        return $urandom_range(20, 80);
    endfunction

    function automatic int random_height(int window);
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return $urandom_range(0, window);
        if (r < 55) return -1;
        if (r < 65) return $urandom_range(200, 255);
        if (r < 75) return -int'($urandom_range(2, 256));
        return int'($urandom_range(0, 511)) - 256;
    endfunction

    task automatic send_request(lsom_pkg::t_opcode op, int lay, int height);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_bus.valid <= 1'b1;
        req_bus.opcode <= op;
        req_bus.layer <= lsom_pkg::t_layer'(lay);
        req_bus.requested_height <= lsom_pkg::t_height'(height);
        @(posedge i_clk);
        while (!req_bus.ready) @(posedge i_clk);
    endtask

    task automatic random_requests(int count, int window);
        int r;
        int lay;
        repeat (count) begin
            r = $urandom_range(0, 99);
            lay = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, window);
            if (r < 20) begin
                send_request(lsom_pkg::OP_ALLOC, $urandom_range(0, 255), random_height(255));
            end else if (r < 72) begin
                send_request(lsom_pkg::OP_SET, lay, random_height(window));
            end else if (r < 96) begin
                send_request(lsom_pkg::OP_FREE, lay, random_height(255));
            end else begin
                send_request(OP_RESERVED, lay, random_height(255));
            end
        end
    endtask

    task automatic shuffle_layers();
        int i;
        int j;
        int t;
        for (i = lsom_pkg::LAYER_COUNT - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            t = layer_order[i];
            layer_order[i] = layer_order[j];
            layer_order[j] = t;
        end
    endtask

    // Allocating the whole pool, raising every layer to the top and then freeing
    // them all drives the stack through its deepest shifts and its full state.
    task automatic fill_and_drain_stack();
        int i;
        repeat (lsom_pkg::LAYER_COUNT + 4) begin
            send_request(lsom_pkg::OP_ALLOC, $urandom_range(0, 255), 0);
        end
        shuffle_layers();
        for (i = 0; i < lsom_pkg::LAYER_COUNT; i++) begin
            send_request(lsom_pkg::OP_SET, layer_order[i], 255);
        end
        repeat (40) send_request(lsom_pkg::OP_SET, $urandom_range(0, 255), random_height(255));
        shuffle_layers();
        for (i = 0; i < lsom_pkg::LAYER_COUNT; i++) begin
            send_request(lsom_pkg::OP_FREE, layer_order[i], random_height(255));
        end
    endtask

    initial begin : receiver
        int gap;
        rsp_bus.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                rsp_bus.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                gap = pick_gap();
                if (gap > 0) begin
                    rsp_bus.ready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
                rsp_bus.ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (req_bus.valid && req_bus.ready)
                    || (rsp_bus.valid && rsp_bus.ready)) begin
                idle = 0;
            end else begin
                idle++;
            end
        end
        $display("Some tests failed");
        $finish;
    end

    initial begin : stimulus
        int i;
        for (i = 0; i < lsom_pkg::LAYER_COUNT; i++) layer_order[i] = i;
        no_idle = 1'b0;
        hold_off_req = 1'b0;
        i_rst_n <= 1'b0;
        req_bus.valid <= 1'b0;
        req_bus.opcode <= lsom_pkg::OP_ALLOC;
        req_bus.layer <= '0;
        req_bus.requested_height <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_request(OP_RESERVED, 255, -1);
        send_request(lsom_pkg::OP_ALLOC, 0, 0);
        send_request(lsom_pkg::OP_ALLOC, 255, 255);
        send_request(lsom_pkg::OP_ALLOC, 85, -256);
        send_request(lsom_pkg::OP_SET, 0, 255);
        send_request(lsom_pkg::OP_SET, 1, -256);
        send_request(lsom_pkg::OP_SET, 1, 0);
        send_request(lsom_pkg::OP_SET, 2, 1);
        send_request(lsom_pkg::OP_SET, 0, 0);
        send_request(lsom_pkg::OP_SET, 0, 255);
        send_request(lsom_pkg::OP_SET, 1, -1);
        send_request(lsom_pkg::OP_SET, 200, -5);
        // Layer 3 is placed while free, so the next allocate takes a visible layer.
        send_request(lsom_pkg::OP_SET, 3, 0);
        send_request(lsom_pkg::OP_ALLOC, 170, 170);
        send_request(lsom_pkg::OP_FREE, 2, 0);
        send_request(lsom_pkg::OP_FREE, 1, 0);
        send_request(lsom_pkg::OP_SET, 255, 0);
        send_request(lsom_pkg::OP_FREE, 255, -1);
        send_request(lsom_pkg::OP_FREE, 200, 255);
        send_request(OP_RESERVED, 0, 0);

        random_requests(300, 31);
        hold_off_req = 1'b1;
        fill_and_drain_stack();
        no_idle = 1'b1;
        hold_off_req = 1'b1;
        random_requests(120, 255);
        no_idle = 1'b0;
        random_requests(130, 63);

        req_bus.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+src
src/lsom_pkg.sv
src/lsom_if.sv
src/layer_stack_order_manager.sv
tb/layer_stack_order_manager_checker.sv
tb/layer_stack_order_manager_test.sv
